// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

    // Request codes on the action field
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_WRITE1 = 2'd2;
    localparam logic [1:0] ACT_WRITE2 = 2'd3;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd8;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // One bus tick: request plus sampled pin levels
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] address_byte;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       scl_in;
        logic       sda_in;
    } t_in_item;

    // Pin drives and status for one tick
    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       address_acked;
        logic [7:0] read_data;
    } t_out_item;

endpackage

// ===== sv/i2cm_in_if.sv =====
interface i2cm_in_if;
    logic               valid;
    logic               ready;
    i2cm_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/i2cm_out_if.sv =====
interface i2cm_out_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/i2c_master_byte_transactions_core.sv =====
// I2C bus master for single-byte read, single-byte write and two-byte write
// transactions with clock stretching. Each transfer on i_in is one bus tick:
// it carries a request (acted on only when idle) and the sampled SCL/SDA
// levels, and yields exactly one result on o_out with the line drives for
// that tick and the status after it. The block takes one tick per clock;
// the result is registered, so it appears the cycle after the input
// transfer, and i_in stalls only while that result register is full and not
// taken. i_cfg_wr_en/i_cfg_wr_data load the ticks-per-SCL-phase register
// (reset 8, zero counts as one); write it only while the bus is idle.
module i2c_master_byte_transactions_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    i2cm_in_if.sink    i_in,
    i2cm_out_if.source o_out
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_TX_LOW    = 4'd2,
        PH_TX_HIGH   = 4'd3,
        PH_ACK_LOW   = 4'd4,
        PH_ACK_HIGH  = 4'd5,
        PH_RX_LOW    = 4'd6,
        PH_RX_HIGH   = 4'd7,
        PH_NACK_LOW  = 4'd8,
        PH_NACK_HIGH = 4'd9,
        PH_STOP_LOW  = 4'd10,
        PH_STOP_HIGH = 4'd11,
        PH_STOP_HOLD = 4'd12
    } t_phase;

    logic [7:0]  r_phase_ticks;
    t_phase      r_phase,   n_phase;
    logic [7:0]  r_tick,    n_tick;
    logic [3:0]  r_bits,    n_bits;
    logic [1:0]  r_byte_ix, n_byte_ix;
    logic [7:0]  r_shift,   n_shift;
    logic [15:0] r_pending, n_pending;
    logic [1:0]  r_op,      n_op;
    logic        r_ack,     n_ack;
    logic [7:0]  r_rx,      n_rx;
    logic        r_out_valid;
    t_out_item   r_out,     n_out;

    logic       w_accept;
    logic [7:0] w_limit;
    logic       w_waits_scl;
    logic       w_hold;
    logic [8:0] w_next;
    logic       w_end;
    logic [3:0] w_bits_inc;
    t_in_item   w_in;

    assign w_in     = i_in.payload;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Phase timer: high phases pause while SCL is held low
    assign w_limit     = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign w_waits_scl = (r_phase == PH_TX_HIGH)   || (r_phase == PH_ACK_HIGH) ||
                         (r_phase == PH_RX_HIGH)   || (r_phase == PH_NACK_HIGH) ||
                         (r_phase == PH_STOP_HIGH);
    assign w_hold      = w_waits_scl && !w_in.scl_in;
    assign w_next      = {1'b0, r_tick} + 9'd1;
    assign w_end       = !w_hold && (w_next >= {1'b0, w_limit});
    assign w_bits_inc  = r_bits + 4'd1;

    // Next state and result for one tick
    always_comb begin
        n_phase   = r_phase;
        n_bits    = r_bits;
        n_byte_ix = r_byte_ix;
        n_shift   = r_shift;
        n_pending = r_pending;
        n_op      = r_op;
        n_ack     = r_ack;
        n_rx      = r_rx;
        if (w_hold) begin
            n_tick = r_tick;
        end else if (w_end) begin
            n_tick = 8'd0;
        end else begin
            n_tick = w_next[7:0];
        end

        n_out.scl_drive = 1'b1;
        n_out.sda_drive = 1'b1;
        n_out.busy_res  = 1'b1;
        n_out.done_res  = 1'b0;

        unique case (r_phase)
            PH_START: begin
                n_out.sda_drive = 1'b0;
                if (w_end) begin
                    n_bits  = 4'd0;
                    n_phase = PH_TX_LOW;
                end
            end
            PH_TX_LOW: begin
                n_out.scl_drive = 1'b0;
                n_out.sda_drive = r_shift[7];
                if (w_end) begin
                    n_phase = PH_TX_HIGH;
                end
            end
            PH_TX_HIGH: begin
                n_out.sda_drive = r_shift[7];
                if (w_end) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bits  = w_bits_inc;
                    n_phase = (w_bits_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                end
            end
            PH_ACK_LOW: begin
                n_out.scl_drive = 1'b0;
                if (w_end) begin
                    n_phase = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH: begin
                if (w_end) begin
                    n_bits = 4'd0;
                    if (r_byte_ix == 2'd0) begin
                        // address byte: record the slave's acknowledge
                        n_ack = !w_in.sda_in;
                        if (r_op == ACT_READ) begin
                            n_shift = 8'd0;
                            n_phase = PH_RX_LOW;
                        end else begin
                            n_shift   = r_pending[15:8];
                            n_byte_ix = 2'd1;
                            n_phase   = PH_TX_LOW;
                        end
                    end else if (r_byte_ix == 2'd1 && r_op == ACT_WRITE2) begin
                        n_shift   = r_pending[7:0];
                        n_byte_ix = 2'd2;
                        n_phase   = PH_TX_LOW;
                    end else begin
                        n_phase = PH_STOP_LOW;
                    end
                end
            end
            PH_RX_LOW: begin
                n_out.scl_drive = 1'b0;
                if (w_end) begin
                    n_phase = PH_RX_HIGH;
                end
            end
            PH_RX_HIGH: begin
                if (w_end) begin
                    n_shift = {r_shift[6:0], w_in.sda_in};
                    n_bits  = w_bits_inc;
                    if (w_bits_inc >= BITS_PER_BYTE) begin
                        n_rx    = {r_shift[6:0], w_in.sda_in};
                        n_phase = PH_NACK_LOW;
                    end else begin
                        n_phase = PH_RX_LOW;
                    end
                end
            end
            PH_NACK_LOW: begin
                n_out.scl_drive = 1'b0;
                if (w_end) begin
                    n_phase = PH_NACK_HIGH;
                end
            end
            PH_NACK_HIGH: begin
                if (w_end) begin
                    n_phase = PH_STOP_LOW;
                end
            end
            PH_STOP_LOW: begin
                n_out.scl_drive = 1'b0;
                n_out.sda_drive = 1'b0;
                if (w_end) begin
                    n_phase = PH_STOP_HIGH;
                end
            end
            PH_STOP_HIGH: begin
                n_out.sda_drive = 1'b0;
                if (w_end) begin
                    n_phase = PH_STOP_HOLD;
                end
            end
            PH_STOP_HOLD: begin
                if (w_end) begin
                    n_out.done_res = 1'b1;
                    n_phase        = PH_IDLE;
                end
            end
            default: begin
                // idle: latch a new request
                n_out.busy_res = 1'b0;
                n_phase        = PH_IDLE;
                n_tick         = 8'd0;
                if (w_in.action != ACT_NONE) begin
                    n_op      = w_in.action;
                    n_pending = {w_in.first_byte, w_in.second_byte};
                    n_byte_ix = 2'd0;
                    n_bits    = 4'd0;
                    n_shift   = (w_in.action == ACT_READ) ? (w_in.address_byte + 8'd1)
                                                          : w_in.address_byte;
                    n_phase   = PH_START;
                end
            end
        endcase

        n_out.address_acked = n_ack;
        n_out.read_data     = n_rx;
    end

    // State, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_phase       <= PH_IDLE;
            r_tick        <= 8'd0;
            r_bits        <= 4'd0;
            r_byte_ix     <= 2'd0;
            r_shift       <= 8'd0;
            r_pending     <= 16'd0;
            r_op          <= ACT_NONE;
            r_ack         <= 1'b0;
            r_rx          <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bits    <= n_bits;
                r_byte_ix <= n_byte_ix;
                r_shift   <= n_shift;
                r_pending <= n_pending;
                r_op      <= n_op;
                r_ack     <= n_ack;
                r_rx      <= n_rx;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/i2cm_checker.sv =====
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_scl_drive,
    input logic       i_sda_drive,
    input logic       i_busy_res,
    input logic       i_done_res,
    input logic [7:0] i_read_data
);

    // stop completes only inside a transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_done_res || i_busy_res))
        else $error("done without busy");

    // an idle master leaves both lines released
    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_busy_res) |-> (i_scl_drive && i_sda_drive))
        else $error("idle master drives the bus");

    // an empty result register never stalls the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_read_data)))
        else $error("stalled result changed");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind i2c_master_byte_transactions_core i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_scl_drive (o_out.payload.scl_drive),
    .i_sda_drive (o_out.payload.sda_drive),
    .i_busy_res  (o_out.payload.busy_res),
    .i_done_res  (o_out.payload.done_res),
    .i_read_data (o_out.payload.read_data)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    // Bus phases as the master steps through a transaction
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
        PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_LOW,
        PH_STOP_HIGH, PH_STOP_HOLD
    } bus_phase_e;

    // Mirror of the master: predicts the drives and status of each tick
    class bus_master_mirror;
        logic [7:0]  phase_ticks;
        bus_phase_e  phase;
        logic [7:0]  tick_count;
        logic [3:0]  bit_count;
        logic [1:0]  byte_index;
        logic [7:0]  shift_reg;
        logic [15:0] pending_bytes;
        logic [1:0]  op_kind;
        logic        ack_reg;
        logic [7:0]  rx_byte;
        t_out_item   pending_drives[$];
        int          mismatches;

        function new();
            phase_ticks   = PHASE_TICKS_RESET;
            phase         = PH_IDLE;
            tick_count    = '0;
            bit_count     = '0;
            byte_index    = '0;
            shift_reg     = '0;
            pending_bytes = '0;
            op_kind       = ACT_NONE;
            ack_reg       = 1'b0;
            rx_byte       = '0;
            mismatches    = 0;
        endfunction

        // Count one tick of the current SCL phase; 1 when the phase ends
        function bit phase_over(bit waits_for_scl, logic scl);
            int limit;
            int nxt;
            limit = (phase_ticks == 0) ? 1 : int'(phase_ticks);
            if (waits_for_scl && !scl)
                return 1'b0;
            nxt = int'(tick_count) + 1;
            if (nxt >= limit) begin
                tick_count = '0;
                return 1'b1;
            end
            tick_count = 8'(nxt);
            return 1'b0;
        endfunction

        function void enter(bus_phase_e ph);
            phase      = ph;
            tick_count = '0;
        endfunction

        // Accepted tick: step the master and queue the result it yields
        function void note_tick(t_in_item it);
            t_out_item want;
            logic      txbit;
            txbit          = shift_reg[7];
            want           = '0;
            want.scl_drive = 1'b1;
            want.sda_drive = 1'b1;
            want.busy_res  = 1'b1;
            case (phase)
                PH_START: begin
                    want.sda_drive = 1'b0;
                    if (phase_over(1'b0, it.scl_in)) begin
                        bit_count = '0;
                        enter(PH_TX_LOW);
                    end
                end
                PH_TX_LOW: begin
                    want.scl_drive = 1'b0;
                    want.sda_drive = txbit;
                    if (phase_over(1'b0, it.scl_in))
                        enter(PH_TX_HIGH);
                end
                PH_TX_HIGH: begin
                    want.sda_drive = txbit;
                    if (phase_over(1'b1, it.scl_in)) begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bit_count = bit_count + 4'd1;
                        enter(bit_count >= BITS_PER_BYTE ? PH_ACK_LOW : PH_TX_LOW);
                    end
                end
                PH_ACK_LOW: begin
                    want.scl_drive = 1'b0;
                    if (phase_over(1'b0, it.scl_in))
                        enter(PH_ACK_HIGH);
                end
                PH_ACK_HIGH: begin
                    if (phase_over(1'b1, it.scl_in)) begin
                        bit_count = '0;
                        if (byte_index == 2'd0) begin
                            ack_reg = ~it.sda_in;
                            if (op_kind == ACT_READ) begin
                                shift_reg = '0;
                                enter(PH_RX_LOW);
                            end else begin
                                shift_reg  = pending_bytes[15:8];
                                byte_index = 2'd1;
                                enter(PH_TX_LOW);
                            end
                        end else if (byte_index == 2'd1 && op_kind == ACT_WRITE2) begin
                            shift_reg  = pending_bytes[7:0];
                            byte_index = 2'd2;
                            enter(PH_TX_LOW);
                        end else begin
                            enter(PH_STOP_LOW);
                        end
                    end
                end
                PH_RX_LOW: begin
                    want.scl_drive = 1'b0;
                    if (phase_over(1'b0, it.scl_in))
                        enter(PH_RX_HIGH);
                end
                PH_RX_HIGH: begin
                    if (phase_over(1'b1, it.scl_in)) begin
                        shift_reg = {shift_reg[6:0], it.sda_in};
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= BITS_PER_BYTE) begin
                            rx_byte = shift_reg;
                            enter(PH_NACK_LOW);
                        end else begin
                            enter(PH_RX_LOW);
                        end
                    end
                end
                PH_NACK_LOW: begin
                    want.scl_drive = 1'b0;
                    if (phase_over(1'b0, it.scl_in))
                        enter(PH_NACK_HIGH);
                end
                PH_NACK_HIGH: begin
                    if (phase_over(1'b1, it.scl_in))
                        enter(PH_STOP_LOW);
                end
                PH_STOP_LOW: begin
                    want.scl_drive = 1'b0;
                    want.sda_drive = 1'b0;
                    if (phase_over(1'b0, it.scl_in))
                        enter(PH_STOP_HIGH);
                end
                PH_STOP_HIGH: begin
                    want.sda_drive = 1'b0;
                    if (phase_over(1'b1, it.scl_in))
                        enter(PH_STOP_HOLD);
                end
                PH_STOP_HOLD: begin
                    if (phase_over(1'b0, it.scl_in)) begin
                        want.done_res = 1'b1;
                        enter(PH_IDLE);
                    end
                end
                default: begin
                    // idle: a request is taken only here
                    want.busy_res = 1'b0;
                    enter(PH_IDLE);
                    if (it.action != ACT_NONE) begin
                        op_kind       = it.action;
                        pending_bytes = {it.first_byte, it.second_byte};
                        byte_index    = 2'd0;
                        bit_count     = '0;
                        shift_reg     = (it.action == ACT_READ) ?
                                        it.address_byte + 8'd1 : it.address_byte;
                        enter(PH_START);
                    end
                end
            endcase
            want.address_acked = ack_reg;
            want.read_data     = rx_byte;
            pending_drives.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Accepted result: compare with the oldest prediction
        function void check_drive(t_out_item got);
            t_out_item want;
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_drives.pop_front();
            compare_field("scl_drive", want.scl_drive, got.scl_drive);
            compare_field("sda_drive", want.sda_drive, got.sda_drive);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("address_acked", want.address_acked, got.address_acked);
            compare_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    i2cm_in_if  tick_bus ();
    i2cm_out_if drive_bus ();

    bus_master_mirror mirror = new();

    int src_idle_pct = 14;
    int rcv_idle_pct = 84;
    bit pressure_armed = 1'b0;

    i2c_master_byte_transactions_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (tick_bus),
        .o_out         (drive_bus)
    );

    always #1 i_clk = ~i_clk;

    // Receiving side: check each result transfer, stall at random, and
    // once hold off for a long stretch while ticks keep being offered
    initial begin
        int  hold_left;
        bit  pressure_given;
        hold_left       = 0;
        pressure_given  = 1'b0;
        drive_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && drive_bus.valid && drive_bus.ready)
                mirror.check_drive(drive_bus.payload);
            if (hold_left > 0) begin
                hold_left--;
                drive_bus.ready <= 1'b0;
            end else if (pressure_armed && !pressure_given && drive_bus.valid) begin
                hold_left       = 400;
                pressure_given  = 1'b1;
                drive_bus.ready <= 1'b0;
            end else begin
                drive_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Offer one tick, with random gaps, and note it once transferred
    task automatic send_tick(t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            tick_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_bus.valid   <= 1'b1;
        tick_bus.payload <= it;
        do @(posedge i_clk); while (!tick_bus.ready);
        mirror.note_tick(it);
    endtask

    function automatic logic [1:0] pick_action();
        case ($urandom_range(0, 9))
            0:       return ACT_NONE;
            1, 2, 3: return ACT_READ;
            4, 5, 6: return ACT_WRITE1;
            default: return ACT_WRITE2;
        endcase
    endfunction

    // Start one transaction from idle and clock it to its stop condition.
    // sda_mode 0/1 holds SDA at that level, anything else randomises it.
    task automatic run_transaction(logic [1:0] act, logic [7:0] addr, logic [7:0] b1,
                                   logic [7:0] b2, int sda_mode, int stretch_pct);
        t_in_item it;
        it.action       = act;
        it.address_byte = addr;
        it.first_byte   = b1;
        it.second_byte  = b2;
        it.scl_in       = 1'b1;
        it.sda_in       = 1'($urandom_range(0, 1));
        send_tick(it);
        while (mirror.phase != PH_IDLE) begin
            // requests offered mid-transaction must be ignored
            it.action       = pick_action();
            it.address_byte = 8'($urandom_range(0, 255));
            it.first_byte   = 8'($urandom_range(0, 255));
            it.second_byte  = 8'($urandom_range(0, 255));
            it.scl_in       = ($urandom_range(0, 99) >= stretch_pct);
            it.sda_in       = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 :
                              1'($urandom_range(0, 1));
            send_tick(it);
        end
    endtask

    // Random ticks, then idle ticks until the bus is released
    task automatic run_random(int count);
        t_in_item it;
        repeat (count) begin
            it.action       = pick_action();
            it.address_byte = 8'($urandom_range(0, 255));
            it.first_byte   = 8'($urandom_range(0, 255));
            it.second_byte  = 8'($urandom_range(0, 255));
            it.scl_in       = ($urandom_range(0, 9) != 0);
            it.sda_in       = 1'($urandom_range(0, 1));
            send_tick(it);
        end
        while (mirror.phase != PH_IDLE) begin
            it        = '0;
            it.action = ACT_NONE;
            it.scl_in = 1'b1;
            it.sda_in = 1'($urandom_range(0, 1));
            send_tick(it);
        end
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain();
        tick_bus.valid <= 1'b0;
        while (mirror.pending_drives.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write only with the bus idle and nothing in flight
    task automatic set_phase_ticks(logic [7:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en          <= 1'b0;
        mirror.phase_ticks = value;
    endtask

    // Main sequence
    initial begin
        t_in_item quiet;
        tick_bus.valid   = 1'b0;
        tick_bus.payload = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset phase length, acked write with extreme bytes
        run_transaction(ACT_WRITE1, 8'hFF, 8'h00, 8'hFF, 0, 10);

        // zero phase length counts as one; a long clock stretch; read
        // address wraps 0xFF to 0x00
        set_phase_ticks(8'd0);
        run_transaction(ACT_WRITE2, 8'hA4, 8'h5A, 8'hC3, 2, 70);
        run_transaction(ACT_READ, 8'hFF, 8'h00, 8'h00, 1, 10);
        run_transaction(ACT_WRITE2, 8'h00, 8'hFF, 8'h00, 2, 10);
        run_transaction(ACT_READ, 8'h80, 8'hFF, 8'hFF, 0, 10);

        // idle tick with all three byte fields at their top value and no request
        set_phase_ticks(8'd1);
        quiet.action       = ACT_NONE;
        quiet.address_byte = 8'hFF;
        quiet.first_byte   = 8'hFF;
        quiet.second_byte  = 8'hFF;
        quiet.scl_in       = 1'b0;
        quiet.sda_in       = 1'b1;
        send_tick(quiet);
        run_transaction(ACT_READ, 8'h00, 8'h00, 8'h00, 2, 10);

        // random, slow receiver
        run_random(150);
        set_phase_ticks(8'd2);
        run_random(120);

        // random, slow sender
        drain();
        src_idle_pct = 84;
        rcv_idle_pct = 14;
        set_phase_ticks(8'd3);
        run_random(100);
        set_phase_ticks(8'($urandom_range(1, 4)));
        run_random(100);

        // random, no idling, with the long receiver hold-off
        drain();
        src_idle_pct   = 0;
        rcv_idle_pct   = 0;
        pressure_armed = 1'b1;
        set_phase_ticks(8'd1);
        run_random(150);

        drain();
        repeat (8) @(posedge i_clk);
        if (mirror.pending_drives.size() != 0)
            $display("%0t: %0d results never arrived", $time, mirror.pending_drives.size());
        if (mirror.mismatches == 0 && mirror.pending_drives.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
